### src/ptc_pkg.sv
// ============================================================================
// ptc_pkg: shared constants for the trapezoid PID controller
// Field widths, register map codes and reset values used by the core.
// ============================================================================
`default_nettype none

package ptc_pkg;

    // Default sample width.
    localparam int SENSOR_BITS_DEF = 8;

    // Fixed field widths.
    localparam int GAIN_W  = 16;
    localparam int SET_W   = 8;
    localparam int PER_W   = 16;
    localparam int INTEG_W = 40;
    localparam int OUT_W   = 32;

    // Product accumulator width, large enough for integ_gain * integral.
    localparam int PROD_W = GAIN_W + INTEG_W;

    // Rounding of the integral term: add half, then drop this many bits.
    localparam int ROUND_SH = 17;

    // Configuration bus.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Reset value of the sample period, about 4 ms in 1/65536 s units.
    localparam logic [PER_W-1:0] PERIOD_RST = 16'd262;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_SETPOINT   = 3'd3,
        REG_PERIOD     = 3'd4
    } t_reg;

endpackage

`default_nettype wire

### src/pid_trapezoid_controller_core.sv
// ============================================================================
// pid_trapezoid_controller_core: PID controller with trapezoidal integral
// Each sample transfer yields one drive value transfer: P + I + D, where the
// integral follows the trapezoid rule, the derivative is divided by the
// sample period, and the result saturates to signed 32 bits with 8 fraction
// bits. Each item runs four products in turn on a shared 16-step shift-add
// multiplier (derivative numerator, trapezoid increment, proportional, integral),
// then adds, saturates and registers the result. The restoring divider for the
// derivative term runs alongside the last three products; the sequencer waits
// in S_DWAIT until its quotient is ready. A new sample is taken once the
// previous result has been loaded into the output register; that register
// holds it until the sink takes it.
// ============================================================================
`default_nettype none

module pid_trapezoid_controller_core #(
    parameter int SENSOR_BITS = ptc_pkg::SENSOR_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Sample stream
    input  wire logic                                   s_axis_tvalid,
    output      logic                                   s_axis_tready,
    // tdata: sensor_value (SENSOR_BITS), zero padded to whole bytes
    input  wire logic [((SENSOR_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // Drive value stream
    output      logic                                   m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // tdata: drive_value (32, signed)
    output      logic [ptc_pkg::OUT_W-1:0]              m_axis_tdata,
    // Configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [ptc_pkg::APB_ADDR_W-1:0]         paddr,
    input  wire logic [ptc_pkg::APB_DATA_W-1:0]         pwdata,
    output      logic [ptc_pkg::APB_DATA_W-1:0]         prdata,
    output      logic                                   pready
);

    // Derived widths.
    localparam int GW  = ptc_pkg::GAIN_W;
    localparam int MW  = ptc_pkg::PROD_W;
    localparam int IW  = ptc_pkg::INTEG_W;
    localparam int OW  = ptc_pkg::OUT_W;
    localparam int EW  = ((SENSOR_BITS > ptc_pkg::SET_W) ? SENSOR_BITS : ptc_pkg::SET_W) + 1;
    localparam int DW  = EW + 1;
    localparam int PW  = EW + GW;
    localparam int DPW = DW + GW;
    localparam int NW  = DPW + ptc_pkg::PER_W;
    localparam int SW  = ((NW + 1 > IW) ? NW + 1 : IW) + 2;
    localparam int DCW = $clog2(NW + 1);
    localparam int MCW = $clog2(GW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MSTART,
        S_MUL,
        S_MDONE,
        S_DWAIT,
        S_ADD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_DNUM,
        OP_INC,
        OP_PROP,
        OP_INTEG
    } t_op;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [GW-1:0]                    r_prop_gain;
    logic [GW-1:0]                    r_integ_gain;
    logic [GW-1:0]                    r_deriv_gain;
    logic [ptc_pkg::SET_W-1:0]        r_setpoint;
    logic [ptc_pkg::PER_W-1:0]        r_period;
    ptc_pkg::t_reg                    n_reg_idx;

    assign n_reg_idx = ptc_pkg::t_reg'(paddr[4:2]);
    assign pready    = 1'b1;

    // A register is written in the access phase of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_setpoint   <= '0;
            r_period     <= ptc_pkg::PERIOD_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (n_reg_idx)
                ptc_pkg::REG_PROP_GAIN:  r_prop_gain  <= pwdata[GW-1:0];
                ptc_pkg::REG_INTEG_GAIN: r_integ_gain <= pwdata[GW-1:0];
                ptc_pkg::REG_DERIV_GAIN: r_deriv_gain <= pwdata[GW-1:0];
                ptc_pkg::REG_SETPOINT:   r_setpoint   <= pwdata[ptc_pkg::SET_W-1:0];
                ptc_pkg::REG_PERIOD:     r_period     <= pwdata[ptc_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data follows the address.
    always_comb begin
        case (n_reg_idx)
            ptc_pkg::REG_PROP_GAIN:  prdata = {{(ptc_pkg::APB_DATA_W-GW){1'b0}}, r_prop_gain};
            ptc_pkg::REG_INTEG_GAIN: prdata = {{(ptc_pkg::APB_DATA_W-GW){1'b0}}, r_integ_gain};
            ptc_pkg::REG_DERIV_GAIN: prdata = {{(ptc_pkg::APB_DATA_W-GW){1'b0}}, r_deriv_gain};
            ptc_pkg::REG_SETPOINT:
                prdata = {{(ptc_pkg::APB_DATA_W-ptc_pkg::SET_W){1'b0}}, r_setpoint};
            ptc_pkg::REG_PERIOD:
                prdata = {{(ptc_pkg::APB_DATA_W-ptc_pkg::PER_W){1'b0}}, r_period};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath and sequencer registers
    // ------------------------------------------------------------------------
    t_state             r_state;
    t_op                r_op;
    logic [EW-1:0]      r_err;
    logic [EW-1:0]      r_prev;
    logic [DW-1:0]      r_esum;
    logic [DW-1:0]      r_ediff;
    logic [IW-1:0]      r_integ;
    logic [PW-1:0]      r_p;
    logic [IW-1:0]      r_i;
    logic [SW-1:0]      r_sum;
    logic [MW-1:0]      r_mcand;
    logic [GW-1:0]      r_mplier;
    logic               r_msigned;
    logic [MW-1:0]      r_acc;
    logic [MCW-1:0]     r_mcnt;
    logic               r_out_valid;
    logic [OW-1:0]      r_out_data;

    // Divider registers.
    logic [ptc_pkg::PER_W:0]   r_drem;
    logic [NW-1:0]             r_dq;
    logic [ptc_pkg::PER_W-1:0] r_ddiv;
    logic [DCW-1:0]            r_dcnt;
    logic                      r_dbusy;
    logic                      r_ddone;
    logic                      r_dneg;

    // Error terms of the incoming sample.
    logic [EW-1:0] n_err;
    logic [DW-1:0] n_esum;
    logic [DW-1:0] n_ediff;
    logic          n_accept;

    assign s_axis_tready = (r_state == S_IDLE);
    assign n_accept      = s_axis_tvalid && s_axis_tready;
    assign n_err   = EW'(s_axis_tdata[SENSOR_BITS-1:0]) - EW'(r_setpoint);
    assign n_esum  = {r_prev[EW-1], r_prev} + {n_err[EW-1], n_err};
    assign n_ediff = {n_err[EW-1], n_err} - {r_prev[EW-1], r_prev};

    // One shift-add step: for a signed product the multiplier's sign bit has negative weight.
    logic [MW-1:0] n_addend;
    logic          n_mlast;

    assign n_mlast  = (r_mcnt == MCW'(GW - 1));
    assign n_addend = (n_mlast && r_msigned) ? (~r_mcand + MW'(1)) : r_mcand;

    // Trapezoid increment added to the integral, saturated at 40 bits.
    logic [IW:0]   n_isum;
    logic [IW-1:0] n_integ;

    assign n_isum = {r_integ[IW-1], r_integ} + r_acc[IW:0];
    always_comb begin
        if (n_isum[IW] != n_isum[IW-1]) begin
            n_integ = n_isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            n_integ = n_isum[IW-1:0];
        end
    end

    // Integral term rounded half up.
    logic [MW-1:0] n_iround;

    assign n_iround = r_acc + (MW'(1) << (ptc_pkg::ROUND_SH - 1));

    // Derivative numerator magnitude and sign.
    logic [DPW-1:0] n_dprod;
    logic [DPW-1:0] n_dmag;

    assign n_dprod = r_acc[DPW-1:0];
    assign n_dmag  = n_dprod[DPW-1] ? (~n_dprod + DPW'(1)) : n_dprod;

    // Final sum and saturation.
    logic [NW:0]   n_dval;
    logic [SW-1:0] n_total;
    logic [OW-1:0] n_drive;

    assign n_dval  = r_dneg ? (~{1'b0, r_dq} + (NW+1)'(1)) : {1'b0, r_dq};
    assign n_total = r_sum + {{(SW-NW-1){n_dval[NW]}}, n_dval};
    always_comb begin
        if ((n_total[SW-1:OW-1] == '0) || (n_total[SW-1:OW-1] == '1)) begin
            n_drive = n_total[OW-1:0];
        end else if (n_total[SW-1]) begin
            n_drive = {1'b1, {(OW-1){1'b0}}};
        end else begin
            n_drive = {1'b0, {(OW-1){1'b1}}};
        end
    end

    logic n_div_start;
    logic n_div_take;

    assign n_div_start = (r_state == S_MDONE) && (r_op == OP_DNUM);
    assign n_div_take  = (r_state == S_DWAIT) && r_ddone;

    // Sequencer: four products on the shared multiplier, then wait for the quotient, sum and output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_DNUM;
            r_err       <= '0;
            r_prev      <= '0;
            r_esum      <= '0;
            r_ediff     <= '0;
            r_integ     <= '0;
            r_p         <= '0;
            r_i         <= '0;
            r_sum       <= '0;
            r_mcand     <= '0;
            r_mplier    <= '0;
            r_msigned   <= 1'b0;
            r_acc       <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            // The final step reloads the output register on its own.
            if (r_out_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_err   <= n_err;
                        r_esum  <= n_esum;
                        r_ediff <= n_ediff;
                        r_op    <= OP_DNUM;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_acc  <= '0;
                    r_mcnt <= '0;
                    case (r_op)
                        OP_DNUM: begin
                            r_mcand   <= {{(MW-DW){r_ediff[DW-1]}}, r_ediff};
                            r_mplier  <= r_deriv_gain;
                            r_msigned <= 1'b1;
                        end
                        OP_INC: begin
                            r_mcand   <= {{(MW-DW){r_esum[DW-1]}}, r_esum};
                            r_mplier  <= r_period;
                            r_msigned <= 1'b0;
                        end
                        OP_PROP: begin
                            r_mcand   <= {{(MW-EW){r_err[EW-1]}}, r_err};
                            r_mplier  <= r_prop_gain;
                            r_msigned <= 1'b1;
                        end
                        default: begin
                            r_mcand   <= {{(MW-IW){r_integ[IW-1]}}, r_integ};
                            r_mplier  <= r_integ_gain;
                            r_msigned <= 1'b1;
                        end
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + n_addend;
                    end
                    r_mcand  <= {r_mcand[MW-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[GW-1:1]};
                    r_mcnt   <= r_mcnt + MCW'(1);
                    if (n_mlast) begin
                        r_state <= S_MDONE;
                    end
                end
                S_MDONE: begin
                    case (r_op)
                        OP_DNUM: begin
                            r_op    <= OP_INC;
                            r_state <= S_MSTART;
                        end
                        OP_INC: begin
                            r_integ <= n_integ;
                            r_op    <= OP_PROP;
                            r_state <= S_MSTART;
                        end
                        OP_PROP: begin
                            r_p     <= r_acc[PW-1:0];
                            r_op    <= OP_INTEG;
                            r_state <= S_MSTART;
                        end
                        default: begin
                            r_i     <= {n_iround[MW-1], n_iround[MW-1:ptc_pkg::ROUND_SH]};
                            r_state <= S_DWAIT;
                        end
                    endcase
                end
                S_DWAIT: begin
                    if (r_ddone) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_sum   <= {{(SW-PW){r_p[PW-1]}}, r_p} + {{(SW-IW){r_i[IW-1]}}, r_i};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= n_drive;
                        r_out_valid <= 1'b1;
                        r_prev      <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------------
    // Restoring divider: one quotient bit per cycle, magnitude only
    // ------------------------------------------------------------------------
    logic [ptc_pkg::PER_W:0] n_rem_sh;
    logic [ptc_pkg::PER_W:0] n_rem_sub;
    logic                    n_fits;

    assign n_rem_sh  = {r_drem[ptc_pkg::PER_W-1:0], r_dq[NW-1]};
    assign n_rem_sub = n_rem_sh - {1'b0, r_ddiv};
    assign n_fits    = (n_rem_sh >= {1'b0, r_ddiv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drem  <= '0;
            r_dq    <= '0;
            r_ddiv  <= '0;
            r_dcnt  <= '0;
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_dneg  <= 1'b0;
        end else begin
            if (n_div_take) begin
                r_ddone <= 1'b0;
            end
            if (n_div_start) begin
                // A zero period divides as one.
                r_drem  <= '0;
                r_dq    <= {n_dmag, {ptc_pkg::PER_W{1'b0}}};
                r_ddiv  <= (r_period == '0) ? ptc_pkg::PER_W'(1) : r_period;
                r_dneg  <= n_dprod[DPW-1];
                r_dcnt  <= DCW'(NW);
                r_dbusy <= 1'b1;
                r_ddone <= 1'b0;
            end else if (r_dbusy) begin
                r_drem <= n_fits ? n_rem_sub : n_rem_sh;
                r_dq   <= {r_dq[NW-2:0], n_fits};
                r_dcnt <= r_dcnt - DCW'(1);
                if (r_dcnt == DCW'(1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // A new sample never finds the divider still working on the last one.
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_dbusy)
        else $error("divider busy while the core is idle");

    // A sample transfer always starts the derivative product first.
    a_start_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> (r_state == S_MSTART) && (r_op == OP_DNUM))
        else $error("sample transfer did not start the product sequence");

    // The step counter only moves inside a product.
    a_mcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MUL) |-> (r_mcnt == '0))
        else $error("multiplier step count out of step with the sequencer");

    // A fresh result is loaded only as the sequencer returns to idle.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_state == S_IDLE) && !r_dbusy)
        else $error("result loaded outside the final step");

    // The quotient is consumed only after the divider has finished.
    a_div_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> !r_dbusy && $past(r_ddone))
        else $error("sum formed before the quotient was ready");
`endif

endmodule

`default_nettype wire
